>>> hdl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MPK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mpk_pkg.sv
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared constants for the k-transaction best-profit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mpk_pkg;

  localparam int MAX_LEVELS_DEF = 16;
  localparam int PRICE_BITS_DEF = 16;

  localparam int CFG_W    = 5;
  localparam int PROFIT_W = 20;

  localparam logic [CFG_W-1:0] MAX_TRANSACTIONS_RST = CFG_W'(2);

endpackage

`default_nettype wire

>>> hdl/mpk_if.sv
// ----------------------------------------------------------------------------
// mpk_if
// Valid/ready word channels: price input and profit result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpk_in_if #(
  parameter int PRICE_BITS = mpk_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

interface mpk_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpk_pkg::PROFIT_W-1:0] best_profit;

  modport source (output valid, output best_profit, input ready);
  modport sink   (input valid, input best_profit, output ready);
endinterface

`default_nettype wire

>>> hdl/max_profit_k_transactions_top.sv
// ----------------------------------------------------------------------------
// max_profit_k_transactions_top
// Streaming best profit with at most k buy/sell transactions. One price word
// per cycle; every transaction level updates in parallel with one subtract,
// one add and two compares, and the result for the configured limit is
// registered. A word is taken every cycle while the result is consumed; the
// result is valid the cycle after its price is accepted. The output register
// lets a new price in as soon as the pending result is taken in the same
// cycle. series_start clears the per-level state before its price is used.
// max_transactions above MAX_LEVELS acts as MAX_LEVELS; zero yields zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module max_profit_k_transactions_top #(
  parameter int MAX_LEVELS = mpk_pkg::MAX_LEVELS_DEF,
  parameter int PRICE_BITS = mpk_pkg::PRICE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [mpk_pkg::CFG_W-1:0]  cfg_wdata,
  mpk_in_if.sink                          in_ch,
  mpk_out_if.source                       out_ch
);
  import mpk_pkg::*;

  localparam int SOLD_W = PRICE_BITS + $clog2(MAX_LEVELS + 1);
  localparam int HOLD_W = SOLD_W + 1;
  localparam logic signed [HOLD_W-1:0] HOLD_NONE = {1'b1, {(HOLD_W-1){1'b0}}};

  logic [CFG_W-1:0]           max_transactions_r;
  logic signed [HOLD_W-1:0]   hold_r   [MAX_LEVELS];
  logic [SOLD_W-1:0]          sold_r   [MAX_LEVELS];
  logic signed [HOLD_W-1:0]   hold_nxt [MAX_LEVELS];
  logic [SOLD_W-1:0]          sold_nxt [MAX_LEVELS];
  logic [PROFIT_W-1:0]        best_r;
  logic [PROFIT_W-1:0]        best_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       in_ready;
  logic                       in_acc;
  logic signed [HOLD_W-1:0]   price_x;

  assign in_ready      = !out_valid_r || out_ch.ready;
  assign in_acc        = in_ch.valid && in_ready;
  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.best_profit = best_r;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);
  assign price_x       = $signed(HOLD_W'(in_ch.price));

  genvar g;
  for (g = 0; g < MAX_LEVELS; g++) begin : g_lvl
    logic signed [HOLD_W-1:0] h_old;
    logic [SOLD_W-1:0]        s_old;
    logic signed [HOLD_W-1:0] s_old_x;
    logic signed [HOLD_W-1:0] prev_x;
    logic signed [HOLD_W-1:0] buy;
    logic signed [HOLD_W-1:0] sell;

    assign h_old   = in_ch.series_start ? HOLD_NONE : hold_r[g];
    assign s_old   = in_ch.series_start ? '0 : sold_r[g];
    assign s_old_x = $signed(HOLD_W'(s_old));

    if (g == 0) begin : g_first
      assign prev_x = '0;
    end else begin : g_rest
      assign prev_x = in_ch.series_start ? '0 : $signed(HOLD_W'(sold_r[g-1]));
    end

    assign buy  = prev_x - price_x;
    assign sell = h_old + price_x;
    assign hold_nxt[g] = (buy > h_old) ? buy : h_old;
    assign sold_nxt[g] = (sell > s_old_x) ? SOLD_W'(sell) : s_old;
  end

  // Level select: limit k picks level k-1, saturating at the top level.
  always_comb begin
    best_nxt = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (int'(max_transactions_r) == i + 1 ||
          (i == MAX_LEVELS - 1 && int'(max_transactions_r) > MAX_LEVELS)) begin
        best_nxt = PROFIT_W'(sold_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_transactions_r <= MAX_TRANSACTIONS_RST;
      out_valid_r        <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        hold_r[i] <= HOLD_NONE;
        sold_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_transactions_r <= cfg_wdata;
      end
      if (in_acc) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          hold_r[i] <= hold_nxt[i];
          sold_r[i] <= sold_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      best_r <= best_nxt;
    end
  end

  `MPK_ASSERT_NEXT(a_acc_gives_word, in_acc, out_valid_r, "accepted price lost its result")
  `MPK_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ch.ready, !in_ready,
                   "input open while result is stalled")
  `MPK_ASSERT_NEXT(a_start_zero, in_acc && in_ch.series_start, best_r == '0,
                   "first price of a series gave nonzero profit")
  `MPK_ASSERT_NEXT(a_start_hold, in_acc && in_ch.series_start,
                   hold_r[0] == -$past(price_x), "level one hold not set by first price")
  `MPK_ASSERT_NEXT(a_zero_limit, in_acc && max_transactions_r == '0, best_r == '0,
                   "zero limit gave nonzero profit")

endmodule

`default_nettype wire
